FILE: rtl/fad_pkg.sv
// shared types and constants for the accumulate-and-dump integrator
`timescale 1ns / 1ps

package fad_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int ACC_WIDTH    = 48;
    localparam int SUM_WIDTH    = ACC_WIDTH + 1;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int POS_W        = 12;
    localparam int CNT_W        = 13;
    localparam int STEP_W       = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_INNER_COUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRATE_SIZE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_COUNT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_RATE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REAL_ONLY      = 3'd4;

    localparam logic [CNT_W-1:0] CNT_LIMIT = 13'd4096;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_real;
        logic signed [SAMPLE_WIDTH-1:0] sample_imag;
    } sample_t;

    typedef struct packed {
        logic signed [ACC_WIDTH-1:0] sum_real;
        logic signed [ACC_WIDTH-1:0] sum_imag;
        logic                        last_of_frame;
    } sum_t;

    // one classified sample, handed from front to back
    typedef struct packed {
        logic                           first;
        logic                           emit;
        logic                           last;
        logic signed [SAMPLE_WIDTH-1:0] re;
        logic signed [SAMPLE_WIDTH-1:0] im;
    } op_t;

endpackage

FILE: rtl/frame_accumulate_and_dump.sv
// top level of the accumulate-and-dump integrator
//
//  channel   direction  handshake                  payload
//  cfg       in         cfg_wr_en                  cfg_index, cfg_data
//  sample    in         sample_valid/sample_stall  sample (sample_real, sample_imag)
//  sum       out        sum_valid/sum_stall        sum (sum_real, sum_imag, last_of_frame)
//
// one sample per cycle sustained while sum_stall is low; the accumulator memory does one
// read and one write per cycle, with the previous write forwarded to cover the
// read-after-write gap; a sample that closes a period passes through the queue and the
// back-end operand register before its sum loads the output register
// reset clears counters, queue and pipeline valid bits; accumulator contents are not
// cleared, the first step of each period overwrites its entries
// sum_stall holds the output register; sample_stall rises only when the two-entry
// queue between the front and back halves is full
`timescale 1ns / 1ps

module frame_accumulate_and_dump #(
    parameter int DEPTH = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [fad_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fad_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            sample_valid,
    output logic                            sample_stall,
    input  fad_pkg::sample_t                sample,
    output logic                            sum_valid,
    input  logic                            sum_stall,
    output fad_pkg::sum_t                   sum
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic          push, pop, q_valid, q_full;
    fad_pkg::op_t  push_op, head_op;
    logic [AW-1:0] push_addr, head_addr;

    fad_front #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample       (sample),
        .q_full       (q_full),
        .push         (push),
        .op           (push_op),
        .addr         (push_addr)
    );

    fad_queue #(
        .AW (AW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_op   (push_op),
        .push_addr (push_addr),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_full    (q_full),
        .head_op   (head_op),
        .head_addr (head_addr)
    );

    fad_back #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .head_op   (head_op),
        .head_addr (head_addr),
        .pop       (pop),
        .sum_valid (sum_valid),
        .sum_stall (sum_stall),
        .sum       (sum)
    );

    assign sample_stall = q_full;

`ifndef SYNTHESIS
    // the back end never draws from an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("queue popped while empty");

    // a transferred sample is waiting in the queue on the next cycle
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> q_valid)
        else $error("pushed op missing from queue");

    // a full queue drains when the output side is free
    a_full_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (q_full && !sum_valid) |-> pop)
        else $error("full queue not drained");
`endif

endmodule

FILE: rtl/fad_front.sv
// front end: config registers, position counters, address and op classification
`timescale 1ns / 1ps

module fad_front #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [fad_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fad_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             sample_valid,
    input  fad_pkg::sample_t                 sample,
    input  logic                             q_full,
    output logic                             push,
    output fad_pkg::op_t                     op,
    output logic [AW-1:0]                    addr
);

    localparam logic [AW-1:0] ADDR_TOP = AW'(DEPTH - 1);

    logic [fad_pkg::CNT_W-1:0]  inner_count_reg;
    logic [fad_pkg::STEP_W-1:0] integrate_size_reg;
    logic [fad_pkg::CNT_W-1:0]  group_count_reg;
    logic [fad_pkg::STEP_W-1:0] frame_rate_reg;
    logic                       real_only_reg;

    logic [fad_pkg::POS_W-1:0]  inner_reg, inner_next;
    logic [fad_pkg::STEP_W-1:0] step_reg, step_next;
    logic [fad_pkg::POS_W-1:0]  group_reg, group_next;
    logic [fad_pkg::STEP_W-1:0] frame_reg, frame_next;
    logic [AW-1:0]              addr_reg, addr_next;
    logic [AW-1:0]              base_reg, base_next;

    logic [fad_pkg::CNT_W-1:0]  ni, ng;
    logic [fad_pkg::STEP_W-1:0] ns, nf;
    logic inner_last, step_last, group_last, frame_last;
    logic [AW-1:0] addr_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_count_reg    <= 13'd1;
            integrate_size_reg <= 16'd1;
            group_count_reg    <= 13'd1;
            frame_rate_reg     <= 16'd1;
            real_only_reg      <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                fad_pkg::CFG_INNER_COUNT:    inner_count_reg    <= cfg_data[12:0];
                fad_pkg::CFG_INTEGRATE_SIZE: integrate_size_reg <= cfg_data;
                fad_pkg::CFG_GROUP_COUNT:    group_count_reg    <= cfg_data[12:0];
                fad_pkg::CFG_FRAME_RATE:     frame_rate_reg     <= cfg_data;
                fad_pkg::CFG_REAL_ONLY:      real_only_reg      <= cfg_data[0];
                default:                     ;
            endcase
        end
    end

    // zero counts act as one, oversized element counts are capped
    always_comb
    begin
        ni = (inner_count_reg == '0) ? 13'd1 :
             (inner_count_reg > fad_pkg::CNT_LIMIT) ? fad_pkg::CNT_LIMIT : inner_count_reg;
        ng = (group_count_reg == '0) ? 13'd1 :
             (group_count_reg > fad_pkg::CNT_LIMIT) ? fad_pkg::CNT_LIMIT : group_count_reg;
        ns = (integrate_size_reg == '0) ? 16'd1 : integrate_size_reg;
        nf = (frame_rate_reg == '0) ? 16'd1 : frame_rate_reg;
    end

    assign inner_last = ({1'b0, inner_reg} + 13'd1) >= ni;
    assign group_last = ({1'b0, group_reg} + 13'd1) >= ng;
    assign step_last  = ({1'b0, step_reg} + 17'd1) >= {1'b0, ns};
    assign frame_last = ({1'b0, frame_reg} + 17'd1) >= {1'b0, nf};

    assign addr_inc = (addr_reg == ADDR_TOP) ? '0 : addr_reg + AW'(1);

    assign push = sample_valid && !q_full;

    always_comb
    begin
        op.first = (frame_reg == '0) && (step_reg == '0);
        op.emit  = frame_last && step_last;
        op.last  = group_last && inner_last;
        op.re    = sample.sample_real;
        op.im    = real_only_reg ? '0 : sample.sample_imag;
    end

    assign addr = addr_reg;

    // the address tracks group*inner_count+inner modulo DEPTH without a multiply:
    // the next group starts right after the last inner element of this one
    always_comb
    begin
        inner_next = inner_reg;
        step_next  = step_reg;
        group_next = group_reg;
        frame_next = frame_reg;
        addr_next  = addr_reg;
        base_next  = base_reg;
        if (push)
        begin
            priority if (!inner_last)
            begin
                inner_next = inner_reg + 12'd1;
                addr_next  = addr_inc;
            end
            else if (!step_last)
            begin
                inner_next = '0;
                step_next  = step_reg + 16'd1;
                addr_next  = base_reg;
            end
            else if (!group_last)
            begin
                inner_next = '0;
                step_next  = '0;
                group_next = group_reg + 12'd1;
                addr_next  = addr_inc;
                base_next  = addr_inc;
            end
            else
            begin
                inner_next = '0;
                step_next  = '0;
                group_next = '0;
                frame_next = frame_last ? '0 : frame_reg + 16'd1;
                addr_next  = '0;
                base_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_reg <= '0;
            step_reg  <= '0;
            group_reg <= '0;
            frame_reg <= '0;
            addr_reg  <= '0;
            base_reg  <= '0;
        end
        else
        begin
            inner_reg <= inner_next;
            step_reg  <= step_next;
            group_reg <= group_next;
            frame_reg <= frame_next;
            addr_reg  <= addr_next;
            base_reg  <= base_next;
        end
    end

endmodule

FILE: rtl/fad_queue.sv
// two-entry queue of classified ops between front and back
`timescale 1ns / 1ps

module fad_queue #(
    parameter int AW = 12
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  fad_pkg::op_t  push_op,
    input  logic [AW-1:0] push_addr,
    input  logic          pop,
    output logic          q_valid,
    output logic          q_full,
    output fad_pkg::op_t  head_op,
    output logic [AW-1:0] head_addr
);

    fad_pkg::op_t  op_mem [2];
    logic [AW-1:0] addr_mem [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;

    assign q_valid   = (count_reg != 2'd0);
    assign q_full    = (count_reg == 2'd2);
    assign head_op   = op_mem[rd_ptr_reg];
    assign head_addr = addr_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_mem[wr_ptr_reg]   <= push_op;
            addr_mem[wr_ptr_reg] <= push_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/fad_back.sv
// back end: accumulator memory, saturating read-modify-write and output register
`timescale 1ns / 1ps

module fad_back #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  fad_pkg::op_t  head_op,
    input  logic [AW-1:0] head_addr,
    output logic          pop,
    output logic          sum_valid,
    input  logic          sum_stall,
    output fad_pkg::sum_t sum
);

    localparam int ACC = fad_pkg::ACC_WIDTH;
    localparam int SW  = fad_pkg::SAMPLE_WIDTH;
    localparam int SUM = fad_pkg::SUM_WIDTH;
    localparam logic [ACC-1:0] ACC_MAX = {1'b0, {(ACC-1){1'b1}}};
    localparam logic [ACC-1:0] ACC_MIN = {1'b1, {(ACC-1){1'b0}}};

    logic [ACC-1:0] mem_re [DEPTH];
    logic [ACC-1:0] mem_im [DEPTH];

    logic [ACC-1:0] rd_re_reg, rd_im_reg;
    fad_pkg::op_t   b_op_reg;
    logic [AW-1:0]  b_addr_reg;
    logic           b_valid_reg, b_valid_next;

    logic           lw_valid_reg;
    logic [AW-1:0]  lw_addr_reg;
    logic [ACC-1:0] lw_re_reg, lw_im_reg;

    fad_pkg::sum_t  out_reg;
    logic           out_valid_reg, out_valid_next;

    logic           b_fire, out_load;
    logic [ACC-1:0] acc_re, acc_im, new_re, new_im;
    logic [SUM-1:0] sum_re, sum_im;

    assign b_fire   = b_valid_reg && (!b_op_reg.emit || !out_valid_reg || !sum_stall);
    assign pop      = q_valid && (!b_valid_reg || b_fire);
    assign out_load = b_fire && b_op_reg.emit;

    // the write of the op just ahead can land at the same edge as this op's read
    always_comb
    begin
        if (lw_valid_reg && (lw_addr_reg == b_addr_reg))
        begin
            acc_re = lw_re_reg;
            acc_im = lw_im_reg;
        end
        else
        begin
            acc_re = rd_re_reg;
            acc_im = rd_im_reg;
        end
        sum_re = (b_op_reg.first ? '0 : {acc_re[ACC-1], acc_re})
                 + {{(SUM-SW){b_op_reg.re[SW-1]}}, b_op_reg.re};
        sum_im = (b_op_reg.first ? '0 : {acc_im[ACC-1], acc_im})
                 + {{(SUM-SW){b_op_reg.im[SW-1]}}, b_op_reg.im};
        // one bit of growth: top two bits differ only on overflow
        if (sum_re[SUM-1] != sum_re[SUM-2])
            new_re = sum_re[SUM-1] ? ACC_MIN : ACC_MAX;
        else
            new_re = sum_re[ACC-1:0];
        if (sum_im[SUM-1] != sum_im[SUM-2])
            new_im = sum_im[SUM-1] ? ACC_MIN : ACC_MAX;
        else
            new_im = sum_im[ACC-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (b_fire)
        begin
            mem_re[b_addr_reg] <= new_re;
            mem_im[b_addr_reg] <= new_im;
        end
        if (pop)
        begin
            rd_re_reg <= mem_re[head_addr];
            rd_im_reg <= mem_im[head_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b_op_reg   <= head_op;
            b_addr_reg <= head_addr;
        end
        if (b_fire)
        begin
            lw_addr_reg <= b_addr_reg;
            lw_re_reg   <= new_re;
            lw_im_reg   <= new_im;
        end
        if (out_load)
        begin
            out_reg.sum_real      <= new_re;
            out_reg.sum_imag      <= new_im;
            out_reg.last_of_frame <= b_op_reg.last;
        end
    end

    always_comb
    begin
        b_valid_next   = pop ? 1'b1 : (b_fire ? 1'b0 : b_valid_reg);
        out_valid_next = out_load ? 1'b1 : (out_valid_reg && sum_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            lw_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg   <= b_valid_next;
            lw_valid_reg  <= lw_valid_reg || b_fire;
            out_valid_reg <= out_valid_next;
        end
    end

    assign sum_valid = out_valid_reg;
    assign sum       = out_reg;

endmodule
